[sv/cobszr_pkg.sv]
`default_nettype none

package cobszr_pkg;

	localparam int unsigned MAX_FRAME_LEN = 65535;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_CAPACITY   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COUNT_BASE     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_MAX_CODE = 2'd2;

	localparam logic [15:0] OUT_CAPACITY_RST   = 16'hFFFF;
	localparam logic [7:0]  COUNT_BASE_RST     = 8'd1;
	localparam logic [7:0]  BLOCK_MAX_CODE_RST = 8'hFF;

	typedef struct packed {
		logic [15:0] out_capacity;
		logic [7:0]  count_base;
		logic [7:0]  block_max_code;
	} cfg_t;

	typedef struct packed {
		logic        literal_mode;
		logic [7:0]  literals_left;
		logic [15:0] bytes_written;
		logic        halted;
		logic        zero_seen;
		logic        overflow_seen;
	} frame_state_t;

	localparam frame_state_t FRAME_STATE_RST = '{
		literal_mode:  1'b1,
		literals_left: 8'd0,
		bytes_written: 16'd0,
		halted:        1'b0,
		zero_seen:     1'b0,
		overflow_seen: 1'b0
	};

	typedef struct packed {
		logic [7:0]  data_value;
		logic [7:0]  run_count;
		logic        frame_end;
		logic        zero_byte_error;
		logic        overflow_error;
		logic [15:0] out_length;
	} result_t;

endpackage

`default_nettype wire

[sv/cobszr_if.sv]
`default_nettype none

interface cobszr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface cobszr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_value;
	logic [7:0]  run_count;
	logic        frame_end;
	logic        zero_byte_error;
	logic        overflow_error;
	logic [15:0] out_length;

	modport source (
		output valid, output data_value, output run_count, output frame_end,
		output zero_byte_error, output overflow_error, output out_length,
		input ready
	);
	modport sink (
		input valid, input data_value, input run_count, input frame_end,
		input zero_byte_error, input overflow_error, input out_length,
		output ready
	);
endinterface

`default_nettype wire

[sv/cobszr_step.sv]
`default_nettype none

module cobszr_step #(
	parameter int unsigned MAX_FRAME_LEN = cobszr_pkg::MAX_FRAME_LEN
) (
	input  cobszr_pkg::cfg_t         cfg,
	input  cobszr_pkg::frame_state_t cur,
	input  logic [7:0]               in_byte,
	input  logic                     in_last,
	output cobszr_pkg::frame_state_t nxt,
	output logic                     emit,
	output cobszr_pkg::result_t      res
);
	import cobszr_pkg::*;

	localparam int unsigned FRAME_LIMIT   = (MAX_FRAME_LEN < 65535) ? MAX_FRAME_LEN : 65535;
	localparam logic [15:0] FRAME_LIMIT_W = 16'(FRAME_LIMIT);

	logic [15:0] cap;
	logic [15:0] room;
	logic [7:0]  room_clip;
	logic [7:0]  diff;
	logic [7:0]  count;
	logic        clipped;
	logic [7:0]  dval;
	logic [7:0]  rcount;
	frame_state_t upd;

	assign cap       = (cfg.out_capacity > FRAME_LIMIT_W) ? FRAME_LIMIT_W : cfg.out_capacity;
	assign room      = (cur.bytes_written >= cap) ? 16'd0 : cap - cur.bytes_written;
	assign room_clip = (room > 16'd255) ? 8'hFF : room[7:0];
	assign diff      = in_byte - cfg.count_base;

	always_comb begin
		if (in_byte < cfg.count_base) begin
			count   = room_clip;
			clipped = 1'b1;
		end else if ({8'd0, diff} > room) begin
			count   = room[7:0];
			clipped = 1'b1;
		end else begin
			count   = diff;
			clipped = 1'b0;
		end
	end

	always_comb begin
		upd    = cur;
		dval   = 8'd0;
		rcount = 8'd0;
		emit   = 1'b0;
		if (cur.halted) begin
			// ignored until frame end
		end else if (cur.literals_left != 8'd0) begin
			if (in_byte == 8'd0) begin
				upd.zero_seen = 1'b1;
			end
			dval              = in_byte;
			rcount            = 8'd1;
			emit              = 1'b1;
			upd.bytes_written = cur.bytes_written + 16'd1;
			upd.literals_left = cur.literals_left - 8'd1;
		end else if (in_byte == 8'd0 && cfg.count_base != 8'd0) begin
			upd.zero_seen = 1'b1;
			upd.halted    = 1'b1;
		end else begin
			if (clipped) begin
				upd.overflow_seen = 1'b1;
			end
			if (cur.literal_mode) begin
				upd.literals_left = count;
			end else if (count != 8'd0) begin
				rcount            = count;
				emit              = 1'b1;
				upd.bytes_written = cur.bytes_written + {8'd0, count};
			end
			if (in_byte != cfg.block_max_code) begin
				upd.literal_mode = ~cur.literal_mode;
			end
		end
	end

	always_comb begin
		res.data_value      = dval;
		res.run_count       = rcount;
		res.frame_end       = in_last;
		res.zero_byte_error = upd.zero_seen;
		res.overflow_error  = upd.overflow_seen;
		res.out_length      = upd.bytes_written;
		nxt                 = in_last ? FRAME_STATE_RST : upd;
	end

endmodule

`default_nettype wire

[sv/cobs_zero_run_decoder.sv]
`default_nettype none

// COBS-style frame decoder with alternating literal blocks and zero runs. One
// encoded byte is taken per transfer, one every clock cycle as long as results
// are taken: each byte passes through a single combinational step between the
// frame state registers and the output register. A result that waits in the
// output register holds off input until it is taken. A literal byte gives a
// result with run_count 1, a zero-run code of nonzero length gives one result
// with the run length, and the frame's last byte always gives a result carrying
// frame_end, the error flags and the decoded length. Each result is registered
// in the output register. Capacity in force is min(out_capacity, MAX_FRAME_LEN).
// The user makes configuration writes only while no frame is in progress; the
// block itself does not enforce it. Unused register indexes are ignored.
module cobs_zero_run_decoder #(
	parameter int unsigned MAX_FRAME_LEN = cobszr_pkg::MAX_FRAME_LEN
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	cobszr_in_if.sink                                  in_chan,
	cobszr_out_if.source                               out_chan,
	input  wire logic                                  cfg_we,
	input  wire logic [cobszr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [cobszr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cobszr_pkg::*;

	cfg_t         cfg_q;
	frame_state_t state_q;
	frame_state_t state_nxt;
	logic         emit;
	result_t      res;
	result_t      res_q;
	logic         out_valid_q;
	logic         in_xfer;

	assign in_chan.ready = ~out_valid_q | out_chan.ready;
	assign in_xfer       = in_chan.valid & in_chan.ready;

	cobszr_step #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.in_byte (in_chan.in_byte),
		.in_last (in_chan.in_last),
		.nxt     (state_nxt),
		.emit    (emit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_capacity   <= OUT_CAPACITY_RST;
			cfg_q.count_base     <= COUNT_BASE_RST;
			cfg_q.block_max_code <= BLOCK_MAX_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OUT_CAPACITY:   cfg_q.out_capacity   <= cfg_data;
				CFG_COUNT_BASE:     cfg_q.count_base     <= cfg_data[7:0];
				CFG_BLOCK_MAX_CODE: cfg_q.block_max_code <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FRAME_STATE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				state_q <= state_nxt;
			end
			if (in_xfer && (emit || in_chan.in_last)) begin
				out_valid_q <= 1'b1;
			end else if (out_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (emit || in_chan.in_last)) begin
			res_q <= res;
		end
	end

	assign out_chan.valid           = out_valid_q;
	assign out_chan.data_value      = res_q.data_value;
	assign out_chan.run_count       = res_q.run_count;
	assign out_chan.frame_end       = res_q.frame_end;
	assign out_chan.zero_byte_error = res_q.zero_byte_error;
	assign out_chan.overflow_error  = res_q.overflow_error;
	assign out_chan.out_length      = res_q.out_length;

endmodule

`default_nettype wire
